@@ rtl/fpc_pkg.sv @@
// Shared constants and class codes for the finder pattern classifier.
package fpc_pkg;

  localparam int CELL_PIXELS_DEFAULT = 3;
  localparam int CELL_PIXELS_MIN     = 1;
  localparam int CELL_PIXELS_MAX     = 8;

  localparam int PIXEL_W = 8;
  localparam int CLASS_W = 2;

  // Patch side in cells: 7 cells for each of the three alignment squares across.
  localparam int SIDE_CELLS = 21;

  localparam logic [CLASS_W-1:0] CLASS_INVALID   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_FINDER    = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_ALIGNMENT = 2'd2;

endpackage

@@ rtl/finder_pattern_classifier_unit.sv @@
// Top level of the finder pattern classifier: region zero counters and class decision.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------
//  pixel     | in        | pixel_valid / stall | pixel[7:0], zero is dark
//  class     | out       | class_valid / stall | pattern_class[1:0], one per patch
//
//  One pixel word is taken every cycle while pixel_stall is low; a patch of SIDE x
//  SIDE words (SIDE = 21*CELL_PIXELS) gives one class word through stages one and two.
//  Stage one registers the dark flag, region hits and last-pixel flag; stage two
//  holds the five counters and, on the last pixel, the class word register.
//  pixel_stall rises only while a finished class word is stalled and the next
//  last pixel is waiting behind it in stage one; otherwise input never stops.
//  rst (synchronous, active high) clears positions, counters and both valids.
module finder_pattern_classifier_unit #(
  parameter int CELL_PIXELS = fpc_pkg::CELL_PIXELS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic [fpc_pkg::PIXEL_W-1:0] pixel,
  output logic                        class_valid,
  input  logic                        class_stall,
  output logic [fpc_pkg::CLASS_W-1:0] pattern_class
);

  // Geometry: ring width, alignment cell and patch side.
  localparam int RING  = 3 * CELL_PIXELS;
  localparam int ALIGN = 7 * CELL_PIXELS;
  localparam int SIDE  = fpc_pkg::SIDE_CELLS * CELL_PIXELS;
  localparam int PW    = $clog2(SIDE);

  // Largest count each region can reach; sets each counter's width.
  localparam int OUTER_MAX  = SIDE * SIDE - 25 * RING * RING;
  localparam int MIDDLE_MAX = 25 * RING * RING - 9 * RING * RING;
  localparam int LARGE_MAX  = 9 * RING * RING;
  localparam int INNER_MAX  = 25 * RING * RING - ALIGN * ALIGN;
  localparam int SMALL_MAX  = ALIGN * ALIGN;

  localparam int OW = $clog2(OUTER_MAX + 1);
  localparam int MW = $clog2(MIDDLE_MAX + 1);
  localparam int LW = $clog2(LARGE_MAX + 1);
  localparam int IW = $clog2(INNER_MAX + 1);
  localparam int SW = $clog2(SMALL_MAX + 1);
  localparam int RW = $clog2(OUTER_MAX + INNER_MAX + 1);

  // Decision thresholds (all truncating).
  localparam logic [OW-1:0] FINDER_OUTER_MIN  = OW'(((24 * RING * RING) * 2) / 3);
  localparam logic [MW-1:0] FINDER_MIDDLE_MAX = MW'((16 * RING * RING) / 3);
  localparam logic [LW-1:0] FINDER_CENTER_MIN = LW'(((9 * RING * RING) * 2) / 3);
  localparam logic [OW-1:0] ALIGN_OUTER_MAX   = OW'((24 * RING * RING) / 3);
  localparam logic [RW-1:0] ALIGN_RING_MAX    = RW'((8 * ALIGN * ALIGN) / 3);
  localparam logic [SW-1:0] ALIGN_CENTER_MIN  = SW'(((ALIGN * ALIGN) * 2) / 3);

  // Region bounds on one axis.
  localparam logic [PW-1:0] BAND_LO  = PW'(RING);
  localparam logic [PW-1:0] BAND_HI  = PW'(6 * RING);
  localparam logic [PW-1:0] BIG_LO   = PW'(2 * RING);
  localparam logic [PW-1:0] BIG_HI   = PW'(5 * RING);
  localparam logic [PW-1:0] SMALL_LO = PW'(ALIGN);
  localparam logic [PW-1:0] SMALL_HI = PW'(2 * ALIGN);
  localparam logic [PW-1:0] SIDE_LAST = PW'(SIDE - 1);

  typedef struct packed {
    logic dark;
    logic band;
    logic big;
    logic small_sq;
    logic last;
  } pix_info_t;

  // Position of the next pixel.
  logic [PW-1:0] column_position, column_position_next;
  logic [PW-1:0] row_position, row_position_next;

  // Stage one.
  logic      s1_valid, s1_valid_next;
  pix_info_t s1, s1_next;
  logic      s1_advance;
  logic      pixel_accept;

  // Stage two counters.
  logic [OW-1:0] outer_ring_zeros, outer_ring_zeros_next, outer_sum;
  logic [MW-1:0] middle_ring_zeros, middle_ring_zeros_next, middle_sum;
  logic [LW-1:0] large_center_zeros, large_center_zeros_next, large_sum;
  logic [IW-1:0] inner_ring_zeros, inner_ring_zeros_next, inner_sum;
  logic [SW-1:0] small_center_zeros, small_center_zeros_next, small_sum;
  logic [RW-1:0] ring_sum;
  logic [fpc_pkg::CLASS_W-1:0] class_code;
  logic                        class_valid_next;

  assign pixel_accept = pixel_valid && !pixel_stall;

  // A last pixel waits in stage one while the class word register is full and stalled.
  assign s1_advance  = s1_valid && (!s1.last || !class_valid || !class_stall);
  assign pixel_stall = s1_valid && !s1_advance;

  // Raster position and region hits of the incoming pixel.
  always_comb begin
    logic band_x, band_y, big_x, big_y, small_x, small_y;
    band_x  = (column_position >= BAND_LO) && (column_position < BAND_HI);
    band_y  = (row_position >= BAND_LO) && (row_position < BAND_HI);
    big_x   = (column_position >= BIG_LO) && (column_position < BIG_HI);
    big_y   = (row_position >= BIG_LO) && (row_position < BIG_HI);
    small_x = (column_position >= SMALL_LO) && (column_position < SMALL_HI);
    small_y = (row_position >= SMALL_LO) && (row_position < SMALL_HI);

    s1_next.dark     = (pixel == '0);
    s1_next.band     = band_x && band_y;
    s1_next.big      = big_x && big_y;
    s1_next.small_sq = small_x && small_y;
    s1_next.last     = (column_position == SIDE_LAST) && (row_position == SIDE_LAST);

    column_position_next = column_position;
    row_position_next    = row_position;
    if (pixel_accept) begin
      if (column_position == SIDE_LAST) begin
        column_position_next = '0;
        row_position_next    = (row_position == SIDE_LAST) ? '0 : row_position + 1'b1;
      end else begin
        column_position_next = column_position + 1'b1;
      end
    end

    if (pixel_accept) begin
      s1_valid_next = 1'b1;
    end else if (s1_advance) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  // Counts including the pixel in stage one, then the class decision.
  always_comb begin
    outer_sum  = outer_ring_zeros   + OW'(s1.dark && !s1.band);
    middle_sum = middle_ring_zeros  + MW'(s1.dark && s1.band && !s1.big);
    large_sum  = large_center_zeros + LW'(s1.dark && s1.big);
    inner_sum  = inner_ring_zeros   + IW'(s1.dark && s1.band && !s1.small_sq);
    small_sum  = small_center_zeros + SW'(s1.dark && s1.small_sq);
    ring_sum   = RW'(outer_sum) + RW'(inner_sum);

    priority if (outer_sum > FINDER_OUTER_MIN) begin
      class_code = (middle_sum < FINDER_MIDDLE_MAX && large_sum > FINDER_CENTER_MIN)
                   ? fpc_pkg::CLASS_FINDER : fpc_pkg::CLASS_INVALID;
    end else if (outer_sum < ALIGN_OUTER_MAX) begin
      class_code = (ring_sum < ALIGN_RING_MAX && small_sum > ALIGN_CENTER_MIN)
                   ? fpc_pkg::CLASS_ALIGNMENT : fpc_pkg::CLASS_INVALID;
    end else begin
      class_code = fpc_pkg::CLASS_INVALID;
    end

    outer_ring_zeros_next   = outer_ring_zeros;
    middle_ring_zeros_next  = middle_ring_zeros;
    large_center_zeros_next = large_center_zeros;
    inner_ring_zeros_next   = inner_ring_zeros;
    small_center_zeros_next = small_center_zeros;
    if (s1_advance) begin
      if (s1.last) begin
        // Drop the counts: the next pixel opens a new patch.
        outer_ring_zeros_next   = '0;
        middle_ring_zeros_next  = '0;
        large_center_zeros_next = '0;
        inner_ring_zeros_next   = '0;
        small_center_zeros_next = '0;
      end else begin
        outer_ring_zeros_next   = outer_sum;
        middle_ring_zeros_next  = middle_sum;
        large_center_zeros_next = large_sum;
        inner_ring_zeros_next   = inner_sum;
        small_center_zeros_next = small_sum;
      end
    end

    if (s1_advance && s1.last) begin
      class_valid_next = 1'b1;
    end else if (class_valid && !class_stall) begin
      class_valid_next = 1'b0;
    end else begin
      class_valid_next = class_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position    <= '0;
      row_position       <= '0;
      s1_valid           <= 1'b0;
      outer_ring_zeros   <= '0;
      middle_ring_zeros  <= '0;
      large_center_zeros <= '0;
      inner_ring_zeros   <= '0;
      small_center_zeros <= '0;
      class_valid        <= 1'b0;
    end else begin
      column_position    <= column_position_next;
      row_position       <= row_position_next;
      s1_valid           <= s1_valid_next;
      outer_ring_zeros   <= outer_ring_zeros_next;
      middle_ring_zeros  <= middle_ring_zeros_next;
      large_center_zeros <= large_center_zeros_next;
      inner_ring_zeros   <= inner_ring_zeros_next;
      small_center_zeros <= small_center_zeros_next;
      class_valid        <= class_valid_next;
    end
  end

  // Payloads: s1 loads on accept, the class word on a last-pixel advance; else hold.
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1 <= s1_next;
    end
    if (s1_advance && s1.last) begin
      pattern_class <= class_code;
    end
  end

endmodule

@@ rtl/fpc_checker.sv @@
// Port-level checker for the finder pattern classifier, bound to the top level.
module fpc_checker #(
  parameter int CELL_PIXELS = fpc_pkg::CELL_PIXELS_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        pixel_valid,
  input logic                        pixel_stall,
  input logic [fpc_pkg::PIXEL_W-1:0] pixel,
  input logic                        class_valid,
  input logic                        class_stall,
  input logic [fpc_pkg::CLASS_W-1:0] pattern_class
);

  localparam int SIDE = fpc_pkg::SIDE_CELLS * CELL_PIXELS;
  localparam int NW   = $clog2(SIDE * SIDE);
  localparam logic [NW-1:0] PATCH_LAST = NW'(SIDE * SIDE - 1);

  logic [NW-1:0] patch_pixels;
  logic [2:0]    pending;
  logic          pixel_take, class_take, patch_done;

  assign pixel_take = pixel_valid && !pixel_stall;
  assign class_take = class_valid && !class_stall;
  assign patch_done = pixel_take && (patch_pixels == PATCH_LAST);

  // Track patches finished on the input side but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_pixels <= '0;
      pending      <= '0;
    end else begin
      if (pixel_take) begin
        patch_pixels <= patch_done ? '0 : patch_pixels + 1'b1;
      end
      pending <= pending + 3'(patch_done) - 3'(class_take);
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !class_valid)
    else $error("class word valid right after reset");

  a_word_needs_patch: assert property (@(posedge clk) disable iff (rst)
    class_take |-> pending != 3'd0)
    else $error("class word delivered without a completed patch");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more than two finished patches held inside the block");

  a_class_holds: assert property (@(posedge clk) disable iff (rst)
    class_valid && class_stall |=> class_valid && $stable(pattern_class))
    else $error("stalled class word changed or dropped");

  a_pixel_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
    else $error("stalled pixel word changed or dropped");

endmodule

bind finder_pattern_classifier_unit fpc_checker #(
  .CELL_PIXELS(CELL_PIXELS)
) u_fpc_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .class_valid  (class_valid),
  .class_stall  (class_stall),
  .pattern_class(pattern_class)
);
